### hw/rtl/ntte_pkg.sv
`default_nettype none
package ntte_pkg;

  localparam logic [1:0] CMD_GATE    = 2'd0;
  localparam logic [1:0] CMD_OPERAND = 2'd1;
  localparam logic [1:0] CMD_EVAL    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [3:0] KIND_NOT  = 4'd0;
  localparam logic [3:0] KIND_AND  = 4'd1;
  localparam logic [3:0] KIND_OR   = 4'd2;
  localparam logic [3:0] KIND_NAND = 4'd3;
  localparam logic [3:0] KIND_NOR  = 4'd4;
  localparam logic [3:0] KIND_XOR  = 4'd5;
  localparam logic [3:0] KIND_PASS = 4'd6;
  localparam logic [3:0] KIND_DEC  = 4'd7;
  localparam logic [3:0] KIND_MUX  = 4'd8;

  localparam logic REG_INPUT_COUNT  = 1'b0;
  localparam logic REG_OUTPUT_COUNT = 1'b1;

  localparam logic [4:0] COUNT_MAX = 5'd16;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] gate_kind;
    logic [2:0] gate_width;
    logic [7:0] signal_index;
  } item_t;

  typedef struct packed {
    logic [15:0] input_bits;
    logic [15:0] output_bits;
    logic        last_row;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/ntte_ram.sv
`default_nettype none
module ntte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/ntte_ctrl.sv
`default_nettype none
module ntte_ctrl #(
  parameter int MAX_GATES       = 256,
  parameter int MAX_OPERANDS    = 1024,
  parameter int SIGNALS         = 256,
  parameter int MAX_SELECT_BITS = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire ntte_pkg::item_t  item_i,
  output logic                  done_o,
  output ntte_pkg::result_t     result_o,
  input  wire logic [4:0]       in_cnt_i,
  input  wire logic [4:0]       out_cnt_i
);
  import ntte_pkg::*;

  localparam int OW  = $clog2(MAX_OPERANDS + 1);
  localparam int OAW = $clog2(MAX_OPERANDS);
  localparam int GW  = $clog2(MAX_GATES + 1);
  localparam int GAW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int SAW = $clog2(SIGNALS);
  localparam int SW  = $clog2(MAX_SELECT_BITS + 1);
  localparam int SPW = MAX_SELECT_BITS + 1;
  localparam int PW  = $clog2(MAX_OPERANDS + 2 ** (MAX_SELECT_BITS + 1) + 8);
  localparam int CW  = (MAX_SELECT_BITS + 1 > 5) ? MAX_SELECT_BITS + 1 : 5;
  localparam int GRW = 7 + OW;
  localparam int XW  = (SAW > 6) ? SAW + 1 : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY, S_GFETCH, S_GWAIT, S_OPA, S_OPB, S_OPC, S_STEP, S_OUT, S_OUTW, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_A, PH_B, PH_SEL, PH_ZERO, PH_DATA, PH_END
  } phase_e;

  state_e  state_q;
  phase_e  ph_q;
  logic [GW-1:0]  g_total_q, gidx_q;
  logic [OW-1:0]  o_total_q, p_q;
  logic [15:0]    row_q, cur_row_q, obits_q;
  logic [CW-1:0]  cnt_q;
  logic [3:0]     kind_q;
  logic [SW-1:0]  w_q;
  logic [MAX_SELECT_BITS-1:0] sel_q;
  logic           a_q, rv_q, ok_q, one_q;
  logic [PW-1:0]  op_pos_q;
  logic           op_wr_q, op_val_q;
  logic [SIGNALS-1:0] vld_q;
  logic           done_q;
  result_t        res_q;

  logic           accept;
  logic           g_we, o_we, s_we;
  logic [GRW-1:0] g_rdata;
  logic [7:0]     o_rdata;
  logic           s_rdata, s_wdata;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [XW-1:0]  apply_idx, out_idx, op_idx;
  logic           s_rd_ok, s_rd_one;
  logic [15:0]    mask, row_n;
  logic [4:0]     bidx;
  logic [CW:0]    cnt_p1;
  logic [SPW-1:0] span;
  logic [PW-1:0]  pos_p, pos_span, pos_w;
  logic [MAX_SELECT_BITS:0] sel_wide;
  logic [MAX_SELECT_BITS-1:0] sel_n;
  logic           rd_val, gate_more;
  logic [2:0]     gw_raw;
  logic [SW-1:0]  gw_sat;
  logic [SPW-1:0] span_g;
  logic           f_val;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;

  assign g_we = accept && (item_i.command == CMD_GATE) && (g_total_q < GW'(MAX_GATES));
  assign o_we = accept && (item_i.command == CMD_OPERAND) && (o_total_q < OW'(MAX_OPERANDS));

  ntte_ram #(.WIDTH(GRW), .DEPTH(MAX_GATES)) u_gate_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_total_q[GAW-1:0]),
    .wdata_i ({o_total_q, item_i.gate_width, item_i.gate_kind}),
    .raddr_i (gidx_q[GAW-1:0]),
    .rdata_o (g_rdata)
  );

  ntte_ram #(.WIDTH(8), .DEPTH(MAX_OPERANDS)) u_oper_ram (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_total_q[OAW-1:0]),
    .wdata_i (item_i.signal_index),
    .raddr_i (op_pos_q[OAW-1:0]),
    .rdata_o (o_rdata)
  );

  ntte_ram #(.WIDTH(1), .DEPTH(SIGNALS)) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  always_comb begin
    mask = (in_cnt_i >= COUNT_MAX) ? 16'hFFFF : ((16'd1 << in_cnt_i) - 16'd1);
    row_n = row_q & mask;
    bidx = in_cnt_i - 5'd1 - cnt_q[4:0];
    cnt_p1 = {1'b0, cnt_q} + (CW + 1)'(1);
    span = SPW'(1) << w_q;
    pos_p = PW'(p_q);
    pos_span = PW'(span);
    pos_w = PW'(w_q);
    sel_wide = {sel_q, rv_q};
    sel_n = sel_wide[MAX_SELECT_BITS-1:0];
    rd_val = (ok_q & s_rdata) | one_q;
    gate_more = (GW'(gidx_q + GW'(1)) < g_total_q);
    gw_raw = g_rdata[6:4];
    gw_sat = (gw_raw > 3'(MAX_SELECT_BITS)) ? SW'(MAX_SELECT_BITS) : gw_raw[SW-1:0];
    span_g = SPW'(1) << gw_sat;
    case (kind_q)
      KIND_NOT:  f_val = ~a_q;
      KIND_AND:  f_val = a_q & rv_q;
      KIND_OR:   f_val = a_q | rv_q;
      KIND_NAND: f_val = ~(a_q & rv_q);
      KIND_NOR:  f_val = ~(a_q | rv_q);
      KIND_XOR:  f_val = a_q ^ rv_q;
      default:   f_val = a_q;
    endcase

    apply_idx = XW'(2) + XW'(cnt_q[4:0]);
    out_idx = XW'(2) + XW'(in_cnt_i) + XW'(cnt_q[4:0]);
    op_idx = XW'(o_rdata);

    s_we = 1'b0;
    s_waddr = apply_idx[SAW-1:0];
    s_wdata = cur_row_q[bidx[3:0]];
    s_raddr = out_idx[SAW-1:0];
    s_rd_ok = (out_idx < XW'(SIGNALS)) && vld_q[out_idx[SAW-1:0]];
    s_rd_one = (out_idx == XW'(1));
    case (state_q)
      S_APPLY: begin
        s_we = (apply_idx < XW'(SIGNALS));
      end
      S_OPB: begin
        s_waddr = op_idx[SAW-1:0];
        s_wdata = op_val_q;
        s_raddr = op_idx[SAW-1:0];
        s_we = op_wr_q && (op_idx >= XW'(2)) && (op_idx < XW'(SIGNALS));
        s_rd_ok = (op_idx < XW'(SIGNALS)) && vld_q[op_idx[SAW-1:0]];
        s_rd_one = (op_idx == XW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ph_q      <= PH_END;
      g_total_q <= '0;
      o_total_q <= '0;
      row_q     <= '0;
      vld_q     <= '0;
      done_q    <= 1'b0;
      gidx_q    <= '0;
      cnt_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (s_we) begin
        vld_q[s_waddr] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (item_i.command)
              CMD_GATE: begin
                if (g_we) g_total_q <= g_total_q + GW'(1);
              end
              CMD_OPERAND: begin
                if (o_we) o_total_q <= o_total_q + OW'(1);
              end
              CMD_CLEAR: begin
                g_total_q <= '0;
                o_total_q <= '0;
                row_q     <= '0;
                vld_q     <= '0;
              end
              default: begin
                cur_row_q <= row_n;
                cnt_q     <= '0;
                gidx_q    <= '0;
                obits_q   <= '0;
                if (in_cnt_i != 5'd0) state_q <= S_APPLY;
                else if (g_total_q != '0) state_q <= S_GFETCH;
                else if (out_cnt_i != 5'd0) state_q <= S_OUT;
                else state_q <= S_DONE;
              end
            endcase
          end
        end
        S_APPLY: begin
          cnt_q <= cnt_p1[CW-1:0];
          if (cnt_p1 == (CW + 1)'(in_cnt_i)) begin
            cnt_q <= '0;
            if (g_total_q != '0) state_q <= S_GFETCH;
            else if (out_cnt_i != 5'd0) state_q <= S_OUT;
            else state_q <= S_DONE;
          end
        end
        S_GFETCH: begin
          state_q <= S_GWAIT;
        end
        S_GWAIT: begin
          kind_q <= g_rdata[3:0];
          w_q    <= gw_sat;
          p_q    <= g_rdata[GRW-1:7];
          sel_q  <= '0;
          cnt_q  <= '0;
          op_wr_q <= 1'b0;
          state_q <= S_OPA;
          case (g_rdata[3:0])
            KIND_NOT, KIND_AND, KIND_OR, KIND_NAND, KIND_NOR, KIND_XOR, KIND_PASS: begin
              op_pos_q <= PW'(g_rdata[GRW-1:7]);
              ph_q <= PH_A;
            end
            KIND_DEC: begin
              op_pos_q <= PW'(g_rdata[GRW-1:7]);
              if (gw_sat == '0) begin
                op_wr_q <= 1'b1;
                op_val_q <= 1'b0;
                ph_q <= PH_ZERO;
              end else begin
                ph_q <= PH_SEL;
              end
            end
            KIND_MUX: begin
              if (gw_sat == '0) begin
                op_pos_q <= PW'(g_rdata[GRW-1:7]);
                ph_q <= PH_DATA;
              end else begin
                op_pos_q <= PW'(g_rdata[GRW-1:7]) + PW'(span_g);
                ph_q <= PH_SEL;
              end
            end
            default: begin
              gidx_q <= gidx_q + GW'(1);
              if (gate_more) state_q <= S_GFETCH;
              else if (out_cnt_i != 5'd0) state_q <= S_OUT;
              else state_q <= S_DONE;
            end
          endcase
        end
        S_OPA: begin
          if (op_pos_q < PW'(o_total_q)) begin
            state_q <= S_OPB;
          end else begin
            rv_q <= 1'b0;
            state_q <= S_STEP;
          end
        end
        S_OPB: begin
          ok_q  <= s_rd_ok;
          one_q <= s_rd_one;
          state_q <= op_wr_q ? S_STEP : S_OPC;
        end
        S_OPC: begin
          rv_q <= rd_val;
          state_q <= S_STEP;
        end
        S_STEP: begin
          state_q <= S_OPA;
          op_wr_q <= 1'b0;
          case (ph_q)
            PH_A: begin
              a_q <= rv_q;
              op_pos_q <= pos_p + PW'(1);
              ph_q <= PH_B;
            end
            PH_B: begin
              op_wr_q  <= 1'b1;
              op_val_q <= f_val;
              op_pos_q <= ((kind_q == KIND_NOT) || (kind_q == KIND_PASS)) ?
                          pos_p + PW'(1) : pos_p + PW'(2);
              ph_q <= PH_END;
            end
            PH_SEL: begin
              sel_q <= sel_n;
              cnt_q <= cnt_p1[CW-1:0];
              if (cnt_p1 < (CW + 1)'(w_q)) begin
                op_pos_q <= (kind_q == KIND_DEC) ? pos_p + PW'(cnt_p1) :
                            pos_p + pos_span + PW'(cnt_p1);
              end else if (kind_q == KIND_DEC) begin
                cnt_q <= '0;
                op_wr_q <= 1'b1;
                op_val_q <= 1'b0;
                op_pos_q <= pos_p + pos_w;
                ph_q <= PH_ZERO;
              end else begin
                op_pos_q <= pos_p + PW'(sel_n);
                ph_q <= PH_DATA;
              end
            end
            PH_ZERO: begin
              op_wr_q <= 1'b1;
              cnt_q <= cnt_p1[CW-1:0];
              if (cnt_p1 < (CW + 1)'(span)) begin
                op_val_q <= 1'b0;
                op_pos_q <= pos_p + pos_w + PW'(cnt_p1);
              end else begin
                op_val_q <= 1'b1;
                op_pos_q <= pos_p + pos_w + PW'(sel_q);
                ph_q <= PH_END;
              end
            end
            PH_DATA: begin
              op_wr_q <= 1'b1;
              op_val_q <= rv_q;
              op_pos_q <= pos_p + pos_span + pos_w;
              ph_q <= PH_END;
            end
            default: begin
              cnt_q <= '0;
              gidx_q <= gidx_q + GW'(1);
              if (gate_more) state_q <= S_GFETCH;
              else if (out_cnt_i != 5'd0) state_q <= S_OUT;
              else state_q <= S_DONE;
            end
          endcase
        end
        S_OUT: begin
          ok_q  <= s_rd_ok;
          one_q <= s_rd_one;
          state_q <= S_OUTW;
        end
        S_OUTW: begin
          obits_q <= {obits_q[14:0], rd_val};
          cnt_q <= cnt_p1[CW-1:0];
          state_q <= (cnt_p1 == (CW + 1)'(out_cnt_i)) ? S_DONE : S_OUT;
        end
        S_DONE: begin
          done_q <= 1'b1;
          res_q.input_bits  <= cur_row_q;
          res_q.output_bits <= obits_q;
          res_q.last_row    <= (cur_row_q == mask);
          row_q <= (cur_row_q == mask) ? 16'd0 : ((cur_row_q + 16'd1) & mask);
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/netlist_truth_table_evaluator.sv
`default_nettype none
// Gate-level netlist evaluator. Load commands append a gate record or an
// operand while there is room and finish in the cycle they are accepted, so
// busy stays low. An evaluate command holds busy while it applies the inputs,
// then per gate fetches its record and reads and writes its operands (accesses
// past the loaded operands read as zero and write nothing), then reads out the
// output bits and passes a closing state; done_o follows in the next cycle with
// the result. The receiver cannot stall: the result is valid only while done_o
// is high and must be taken then. Clear resets the netlist, the signals and the
// row counter but keeps the counts; configuration writes take effect at once.
module netlist_truth_table_evaluator #(
  parameter int MAX_GATES       = 256,
  parameter int MAX_OPERANDS    = 1024,
  parameter int SIGNALS         = 256,
  parameter int MAX_SELECT_BITS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ntte_pkg::item_t   item_i,
  output logic                   done_o,
  output ntte_pkg::result_t      result_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [4:0]        cfg_data_i
);
  import ntte_pkg::*;

  logic [4:0] in_cnt_q, out_cnt_q, cfg_sat;

  assign cfg_sat = (cfg_data_i > COUNT_MAX) ? COUNT_MAX : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= 5'd1;
      out_cnt_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INPUT_COUNT:  in_cnt_q <= cfg_sat;
        REG_OUTPUT_COUNT: out_cnt_q <= cfg_sat;
        default: begin
        end
      endcase
    end
  end

  ntte_ctrl #(
    .MAX_GATES       (MAX_GATES),
    .MAX_OPERANDS    (MAX_OPERANDS),
    .SIGNALS         (SIGNALS),
    .MAX_SELECT_BITS (MAX_SELECT_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .item_i    (item_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .in_cnt_i  (in_cnt_q),
    .out_cnt_i (out_cnt_q)
  );

endmodule
`default_nettype wire
